FILE: rtl/core/sleep_wakeup_queue_defines.svh
// assertion macros for the sleep/wakeup timer queue
// no dependencies; included inside the modules that check their own logic
`ifndef SLEEP_WAKEUP_QUEUE_DEFINES_SVH
`define SLEEP_WAKEUP_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// next-cycle implication, disabled during reset
`define SWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

FILE: rtl/core/swq_pkg.sv
// shared types, sizes, codes and index helpers of the sleep/wakeup timer queue
// no dependencies
package swq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 63;
  localparam int PORT_ID_BITS = 8;
  localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // command and result codes
  localparam logic CMD_SLEEP   = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic KIND_WOKEN  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef logic [ID_BITS-1:0]      id_t;
  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [PORT_ID_BITS-1:0] port_id_t;

  // one stored queue entry
  typedef struct packed {
    id_t   id;
    time_t wake;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // one result handed from the sequencer to the output register
  typedef struct packed {
    logic     valid;
    logic     kind;
    port_id_t id;
    logic     last;
  } res_t;

  // queue storage port
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } ram_req_t;

  // keep only the id bits that the queue stores
  function automatic id_t id_trim(input port_id_t x);
    logic [15:0] w;
    id_t r;
    w = {8'b0, x};
    for (int i = 0; i < ID_BITS; i++) begin
      r[i] = w[i];
    end
    return r;
  endfunction

  // widen or cut a stored id to the port width
  function automatic port_id_t id_out(input id_t x);
    logic [15:0] w;
    w = 16'(x);
    return w[PORT_ID_BITS-1:0];
  endfunction

  // physical slot of a queue position relative to the head
  function automatic addr_t wrap_add(input addr_t a, input cnt_t b);
    logic [CNT_BITS:0] s;
    s = (CNT_BITS+1)'(a) + (CNT_BITS+1)'(b);
    if (s >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_BITS+1)'(QUEUE_DEPTH);
    end
    return s[ADDR_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/swq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/swq_seq.sv
// sequencer of the timer queue: sorted insert and due-entry pop over one comparator
// depends on swq_pkg and sleep_wakeup_queue_defines.svh
`include "sleep_wakeup_queue_defines.svh"

module swq_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  swq_pkg::id_t      in_id,
  input  swq_pkg::time_t    in_time,
  input  logic              res_ready,
  output swq_pkg::res_t     res,
  output swq_pkg::ram_req_t ram,
  input  swq_pkg::entry_t   rdata
);
  import swq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_REJ     = 3'd3;
  localparam logic [2:0] S_TK_RD   = 3'd4;
  localparam logic [2:0] S_TK_CMP  = 3'd5;
  localparam logic [2:0] S_FLUSH   = 3'd6;

  localparam cnt_t DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
  localparam cnt_t ONE_CNT   = CNT_BITS'(1);

  logic [2:0] state;
  cnt_t       count;
  addr_t      head;
  cnt_t       k;
  logic       cmd_reg;
  id_t        id_reg;
  time_t      t_reg;
  logic       pend_valid;
  id_t        pend_id;

  logic       le;
  cnt_t       k_dec;
  addr_t      ins_rd_addr;
  addr_t      ins_wr_addr;

  // shared wake-time comparator, used by insert and pop alike
  assign le          = rdata.wake <= t_reg;
  assign k_dec       = k - ONE_CNT;
  assign ins_rd_addr = wrap_add(head, k_dec);
  assign ins_wr_addr = wrap_add(head, k);
  assign in_ready    = state == S_IDLE;

  // storage port and result drive
  always_comb begin
    ram.we    = 1'b0;
    ram.waddr = ins_wr_addr;
    ram.wdata = rdata;
    ram.raddr = head;
    res.valid = 1'b0;
    res.kind  = KIND_WOKEN;
    res.id    = id_out(pend_id);
    res.last  = 1'b1;
    case (state)
      S_INS_RD: begin
        ram.raddr = ins_rd_addr;
        if (k == '0) begin
          ram.we    = 1'b1;
          ram.wdata = '{id: id_reg, wake: t_reg};
        end
      end
      S_INS_CMP: begin
        ram.we = 1'b1;
        if (le) begin
          ram.wdata = '{id: id_reg, wake: t_reg};
        end
      end
      S_REJ: begin
        res.valid = res_ready;
        res.kind  = KIND_REJECT;
        res.id    = id_out(id_reg);
      end
      S_TK_CMP: begin
        res.valid = le && pend_valid && res_ready;
        res.last  = 1'b0;
      end
      S_FLUSH: begin
        res.valid = res_ready;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_reg <= in_cmd;
            id_reg  <= in_id;
            t_reg   <= in_time;
            k       <= count;
            if (in_cmd == CMD_TICK) begin
              state <= S_TK_RD;
            end else if (count == DEPTH_CNT) begin
              state <= S_REJ;
            end else begin
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (k == '0) begin
            count <= count + ONE_CNT;
            state <= S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (le) begin
            count <= count + ONE_CNT;
            state <= S_IDLE;
          end else begin
            k     <= k_dec;
            state <= S_INS_RD;
          end
        end
        S_REJ: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_TK_RD: begin
          if (count == '0) begin
            state <= pend_valid ? S_FLUSH : S_IDLE;
          end else begin
            state <= S_TK_CMP;
          end
        end
        S_TK_CMP: begin
          if (!le) begin
            state <= pend_valid ? S_FLUSH : S_IDLE;
          end else if (!pend_valid || res_ready) begin
            pend_valid <= 1'b1;
            pend_id    <= rdata.id;
            head       <= wrap_add(head, ONE_CNT);
            count      <= count - ONE_CNT;
            state      <= S_TK_RD;
          end
        end
        S_FLUSH: begin
          if (res_ready) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  `SWQ_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= DEPTH_CNT)
  `SWQ_ASSERT_NOW(a_res_slot, clk, rst, res.valid, res_ready)
  `SWQ_ASSERT_NOW(a_write_on_sleep, clk, rst, ram.we, cmd_reg == CMD_SLEEP && count < DEPTH_CNT)
  `SWQ_ASSERT_NEXT(a_reject_full, clk, rst, in_valid && in_ready && in_cmd == CMD_SLEEP && count == DEPTH_CNT, state == S_REJ)

endmodule

FILE: rtl/core/sleep_wakeup_queue.sv
// top level of the sleep/wakeup timer queue: stream ports, output register, storage
// depends on swq_pkg, swq_ram and swq_seq
//
// Sorted timer queue of sleeping thread ids. A sleep transfer (tuser 0) inserts
// its id after every entry with a wake time not later than its own; a tick
// transfer (tuser 1) pops every front entry due at the given time, one result
// transfer per entry, the last one of the burst with tlast set. A sleep into a
// full queue gives one result with tuser 1 and the rejected id. Entries live in
// a circular buffer in one ram with a registered read port, and one comparator
// does all wake-time checks, so the block takes one input transfer at a time:
// a sleep reads and compares the stored entries from the back, moving each one
// with a later wake time back one slot; a tick reads and compares the front
// entry and pops it while it is due, one result per popped entry, and a
// rejected sleep gives its result alone. The output register lets the next
// input transfer in while a result still waits.
module sleep_wakeup_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // thread_id [7:0], time_value [70:8], zero [71]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // woken_id [7:0]
  output logic        m_axis_tuser,  // result_kind
  output logic        m_axis_tlast
);
  import swq_pkg::*;

  res_t     res;
  ram_req_t ram;
  entry_t   rdata;
  logic     slot_free;

  // output register is free when empty or being drained
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  swq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_id     (id_trim(s_axis_tdata[7:0])),
    .in_time   (s_axis_tdata[70:8]),
    .res_ready (slot_free),
    .res       (res),
    .ram       (ram),
    .rdata     (rdata)
  );

  swq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_axis_tvalid <= res.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_axis_tdata <= res.id;
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last;
    end
  end

endmodule
